// ===== src/wpm_pkg.sv =====
// Shared types and constants for the wildcard pattern matcher.
// No dependencies; imported by the cell and the top level.
package wpm_pkg;

   localparam int unsigned SYMBOL_W = 8;

   localparam logic [SYMBOL_W-1:0] STAR_CHAR  = 8'h2A;
   localparam logic [SYMBOL_W-1:0] QMARK_CHAR = 8'h3F;

   typedef enum logic [1:0] {
      FUNC_APPEND = 2'd0,
      FUNC_TEXT   = 2'd1,
      FUNC_START  = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   // One item as it travels down the cell chain.
   typedef struct packed {
      logic                valid;
      func_type            func;
      logic [SYMBOL_W-1:0] symbol;
      logic                new_bit;   // updated row bit of the upstream cell
      logic                old_bit;   // row bit of the upstream cell before this item
      logic                matched;
      logic                status;
      logic                has_rsp;
   } token_type;

endpackage

// ===== src/wpm_req_if.sv =====
// Request channel: valid/ready handshake carrying func and symbol.
// Standalone; no package dependency.
interface wpm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] symbol;

   modport source (output valid, output func, output symbol, input ready);
   modport sink   (input valid, input func, input symbol, output ready);
endinterface

// ===== src/wpm_rsp_if.sv =====
// Response channel: valid/ready handshake carrying matched and status.
// Standalone; no package dependency.
interface wpm_rsp_if;
   logic valid;
   logic ready;
   logic matched;
   logic status;

   modport source (output valid, output matched, output status, input ready);
   modport sink   (input valid, input matched, input status, output ready);
endinterface

// ===== src/wpm_cell.sv =====
// One matcher cell: holds one row bit and one pattern byte.
// Depends on wpm_pkg; instantiated in a chain by the top level.
module wpm_cell
   import wpm_pkg::*;
#(
   parameter int unsigned INDEX = 0,
   parameter int unsigned LEN_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  token_type        tok_i,
   input  logic [LEN_W-1:0] len_i,
   output token_type        tok_o,
   output logic [LEN_W-1:0] len_o
);

   localparam logic [LEN_W:0] IDX = (LEN_W+1)'(INDEX);

   logic                bit_ff, bit_in;
   logic [SYMBOL_W-1:0] pat_ff, pat_in;
   token_type           tok_ff, tok_in;
   logic [LEN_W-1:0]    len_ff;

   logic [LEN_W:0] len_x;
   logic           at_len, in_row, at_next, sym_hit;

   assign len_x   = {1'b0, len_i};
   assign at_len  = (IDX == len_x);
   assign in_row  = (IDX != '0) && (IDX <= len_x);
   assign at_next = (IDX == len_x + (LEN_W+1)'(1));
   assign sym_hit = (pat_ff == QMARK_CHAR) || (pat_ff == tok_i.symbol);

   always_comb begin
      bit_in = bit_ff;
      pat_in = pat_ff;
      tok_in = tok_i;
      if (tok_i.valid) begin
         case (tok_i.func)
            FUNC_APPEND: begin
               if (!tok_i.status && at_next) begin
                  bit_in = 1'b0;
                  pat_in = tok_i.symbol;
               end
            end
            FUNC_TEXT: begin
               if (IDX == '0) begin
                  bit_in = 1'b0;
               end else if (in_row) begin
                  if (pat_ff == STAR_CHAR) begin
                     bit_in = bit_ff | tok_i.new_bit;
                  end else if (sym_hit) begin
                     bit_in = tok_i.old_bit;
                  end else begin
                     bit_in = 1'b0;
                  end
               end
               if (at_len) begin
                  tok_in.matched = bit_in;
               end
            end
            FUNC_START: begin
               if (IDX == '0) begin
                  bit_in = 1'b1;
               end else if (in_row) begin
                  bit_in = tok_i.new_bit && (pat_ff == STAR_CHAR);
               end else begin
                  bit_in = 1'b0;
               end
               if (at_len) begin
                  tok_in.matched = bit_in;
               end
            end
            FUNC_CLEAR: begin
               bit_in = (IDX == '0);
            end
            default: begin
               bit_in = bit_ff;
            end
         endcase
      end
      tok_in.new_bit = bit_in;
      tok_in.old_bit = bit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= (IDX == '0);
         tok_ff <= '0;
      end else if (advance) begin
         bit_ff <= bit_in;
         tok_ff <= tok_in;
      end
   end

   // pattern byte and length: no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         pat_ff <= pat_in;
         len_ff <= len_i;
      end
   end

   assign tok_o = tok_ff;
   assign len_o = len_ff;

endmodule

// ===== src/wildcard_pattern_matcher_unit.sv =====
// Top level of the wildcard pattern matcher: request handling, length register,
// cell chain and response register. Depends on wpm_pkg, wpm_req_if, wpm_rsp_if, wpm_cell.

// Streams text against a stored wildcard pattern ('*' any run, '?' any one byte).
// Items: func 0 appends a pattern byte (status 1 if the store of MAX_PATTERN bytes
// is full), 1 feeds a text byte, 2 starts new text, 3 clears the pattern (no
// response). Every other func gives exactly one response; matched tells whether
// the text so far matches the whole pattern. Every item walks a chain of
// MAX_PATTERN+1 cells, one cell per cycle while the chain advances; cell 0 owns
// row bit 0 and each later cell one pattern byte and one bit of the match row, so
// one item is accepted every cycle while the response is not stalled. Its response
// passes through every cell in order and then the response register. A stalled
// response holds the whole chain; req ready drops only while the response
// register is full and not being taken.
module wildcard_pattern_matcher_unit
   import wpm_pkg::*;
#(
   parameter int unsigned MAX_PATTERN = 64
) (
   input  logic       clock,
   input  logic       reset,
   wpm_req_if.sink    req_chan,
   wpm_rsp_if.source  rsp_chan
);

   localparam int unsigned LEN_W  = $clog2(MAX_PATTERN + 1);
   localparam int unsigned NCELLS = MAX_PATTERN + 1;

   logic             advance;
   logic             req_fire;
   logic             full;
   func_type         req_func;
   logic [LEN_W-1:0] len_ff, len_in;

   token_type        tok_head;
   token_type        tok_chain [NCELLS+1];
   logic [LEN_W-1:0] len_chain [NCELLS+1];

   logic rsp_valid_ff, rsp_valid_in;
   logic matched_ff, status_ff;

   // Whole chain moves when the response slot is free or being drained.
   assign advance  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign req_fire = req_chan.valid && advance;
   assign req_func = func_type'(req_chan.func);
   assign full     = (len_ff == LEN_W'(MAX_PATTERN));

   // Item entering cell zero; it sees the pattern length as of its arrival.
   always_comb begin
      tok_head.valid   = req_fire;
      tok_head.func    = req_func;
      tok_head.symbol  = req_chan.symbol;
      tok_head.new_bit = 1'b0;
      tok_head.old_bit = 1'b0;
      tok_head.matched = 1'b0;
      tok_head.status  = (req_func == FUNC_APPEND) && full;
      tok_head.has_rsp = (req_func != FUNC_CLEAR);
   end

   always_comb begin
      len_in = len_ff;
      if (req_fire) begin
         case (req_func)
            FUNC_APPEND: begin
               if (!full) begin
                  len_in = len_ff + LEN_W'(1);
               end
            end
            FUNC_CLEAR: len_in = '0;
            default:    len_in = len_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   assign tok_chain[0] = tok_head;
   assign len_chain[0] = len_ff;

   // Cell k owns row bit k and pattern byte k-1.
   for (genvar k = 0; k < NCELLS; k++) begin : g_cell
      wpm_cell #(
         .INDEX (k),
         .LEN_W (LEN_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_i   (tok_chain[k]),
         .len_i   (len_chain[k]),
         .tok_o   (tok_chain[k+1]),
         .len_o   (len_chain[k+1])
      );
   end

   // Response register at the chain tail; clear items drop out here.
   assign rsp_valid_in = tok_chain[NCELLS].valid && tok_chain[NCELLS].has_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         matched_ff <= tok_chain[NCELLS].matched;
         status_ff  <= tok_chain[NCELLS].status;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.matched = matched_ff;
   assign rsp_chan.status  = status_ff;

endmodule
